### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### design/ilha_pkg.sv
// ----------------------------------------------------------------------------
// ilha_pkg
// Constants, word types and controller/datapath interface types of the
// implicit list heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ilha_pkg;

   localparam int HEAP_BYTES     = 4096;
   localparam int HEADER_BYTES   = 8;
   localparam int GRANULE_BYTES  = 16;
   localparam int MIN_SPLIT_PAY  = 16;

   localparam int NGRAN          = HEAP_BYTES / GRANULE_BYTES;
   localparam int GW             = $clog2(NGRAN);
   localparam int SPAN_W         = GW + 1;
   localparam int GS             = $clog2(GRANULE_BYTES);
   localparam int MIN_SPLIT_GRAN =
      (HEADER_BYTES + MIN_SPLIT_PAY + GRANULE_BYTES - 1) / GRANULE_BYTES;

   localparam int SIZE_W         = 13;
   localparam int OFFSET_W       = 12;
   localparam int TGT_W          = OFFSET_W - GS;
   localparam int NEED_W         = SIZE_W + 1 - GS;
   localparam int CW             = (NEED_W > SPAN_W + 1) ? NEED_W : SPAN_W + 1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NOFIT  = 2'd1,
      STATUS_BADPTR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_ALLOC,
      WR_SPLIT,
      WR_TGT,
      WR_PREV
   } wr_op_type;

   typedef struct packed {
      logic                req_type;
      logic [SIZE_W-1:0]   alloc_size;
      logic [OFFSET_W-1:0] free_offset;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [OFFSET_W-1:0] payload_offset;
   } rsp_word_type;

   typedef struct packed {
      logic       alloc;
      logic [SPAN_W-1:0] span;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       rd_pos;
      logic       rd_next;
      logic       keep_prev;
      logic       keep_g;
      logic       merge;
      wr_op_type  wr_op;
      logic       finish;
      status_type fin_status;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic size_zero;
      logic bad_ptr;
      logic g_ok;
      logic fit;
      logic split;
      logic at_target;
      logic past_target;
      logic next_end;
      logic alloc_bit;
      logic prev_merge;
   } sts_type;

endpackage

`default_nettype wire

### design/implicit_list_heap_allocator.sv
// An allocate walks the blocks one header at a time and adds a split write when
// it splits; a free walks to its block and may merge the next and previous ones.
// One request at a time; the next is taken in the strobe cycle at the earliest.
// One header per cycle, set by the single table read port. The receiver cannot
// stall. busy drops in the strobe cycle.
// Synchronous reset leaves one free block spanning the heap; no clearing pass.
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator
// First-fit allocator over an implicit list of granule-aligned blocks, with
// splitting on allocate and coalescing on free.
// ----------------------------------------------------------------------------
`default_nettype none

module implicit_list_heap_allocator (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  ilha_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output ilha_pkg::rsp_word_type rsp_word
);
   import ilha_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ilha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy),
      .done  (rsp_strobe)
   );

   ilha_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .sts      (sts),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

### design/ilha_ctrl.sv
// ----------------------------------------------------------------------------
// ilha_ctrl
// Sequencer for allocate and free requests: walks the block list one header
// per cycle and orders the table writes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ilha_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  ilha_pkg::sts_type sts,
   output ilha_pkg::cmd_type cmd,
   output logic             busy,
   output logic             done
);
   import ilha_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      START,
      WALK,
      NEXT_EVAL,
      SPLIT_WR,
      TGT_WR,
      PREV_WR
   } state_type;

   state_type  state_ff, state_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   status_type fail_code;

   always_comb begin
      cmd       = '0;
      cmd.wr_op = WR_NONE;
      cmd.fin_status = STATUS_OK;
      state_in  = state_ff;
      fail_code = sts.is_free ? STATUS_BADPTR : STATUS_NOFIT;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = START;
            end
         end
         START: begin
            if (sts.is_free ? sts.bad_ptr : sts.size_zero) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = fail_code;
            end else begin
               cmd.rd_pos = 1'b1;
               state_in   = WALK;
            end
         end
         WALK: begin
            if (!sts.g_ok) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = fail_code;
            end else if (!sts.is_free) begin
               if (sts.fit) begin
                  cmd.wr_op  = WR_ALLOC;
                  cmd.keep_g = 1'b1;
                  if (sts.split) begin
                     state_in = SPLIT_WR;
                  end else begin
                     cmd.finish = 1'b1;
                  end
               end else if (sts.next_end) begin
                  cmd.finish     = 1'b1;
                  cmd.fin_status = fail_code;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end else if (sts.at_target) begin
               if (sts.alloc_bit) begin
                  cmd.keep_g = 1'b1;
                  if (sts.next_end) begin
                     state_in = TGT_WR;
                  end else begin
                     cmd.rd_next = 1'b1;
                     state_in    = NEXT_EVAL;
                  end
               end else begin
                  cmd.finish     = 1'b1;
                  cmd.fin_status = fail_code;
               end
            end else if (sts.past_target || sts.next_end) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = fail_code;
            end else begin
               cmd.keep_prev = 1'b1;
               cmd.rd_next   = 1'b1;
            end
         end
         NEXT_EVAL: begin
            cmd.merge = 1'b1;
            state_in  = TGT_WR;
         end
         SPLIT_WR: begin
            cmd.wr_op  = WR_SPLIT;
            cmd.finish = 1'b1;
         end
         TGT_WR: begin
            cmd.wr_op = WR_TGT;
            if (sts.prev_merge) begin
               state_in = PREV_WR;
            end else begin
               cmd.finish = 1'b1;
            end
         end
         PREV_WR: begin
            cmd.wr_op  = WR_PREV;
            cmd.finish = 1'b1;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      if (cmd.finish) begin
         state_in = IDLE;
      end
      busy_in = (state_in != IDLE);
      done_in = cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

   `ASSERT_NEVER(a_done_not_busy, clock, reset, done_ff && busy_ff, "strobe while busy")
   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy_ff) |=> busy_ff, "accept not taken")
   `ASSERT_CLK(a_done_single, clock, reset, done_ff |=> !done_ff, "strobe longer than a cycle")
   `ASSERT_CLK(a_wr_busy, clock, reset, (cmd.wr_op != WR_NONE) |-> busy_ff, "table write while idle")

endmodule

`default_nettype wire

### design/ilha_dp.sv
// ----------------------------------------------------------------------------
// ilha_dp
// Header table memory, walk position, previous-block tracking and the
// result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilha_dp (
   input  wire                    clock,
   input  wire                    reset,
   input  ilha_pkg::cmd_type      cmd,
   input  ilha_pkg::req_word_type req_word,
   output ilha_pkg::sts_type      sts,
   output ilha_pkg::rsp_word_type rsp_word
);
   import ilha_pkg::*;

   entry_type            mem [NGRAN];
   logic [NGRAN-1:0]     valid_ff;
   entry_type            mem_q_ff;
   logic                 valid_q_ff;
   logic [GW-1:0]        addr_q_ff;
   entry_type            rd_entry;

   logic                 is_free_ff;
   logic                 size_zero_ff;
   logic                 bad_ptr_ff;
   logic [NEED_W-1:0]    need_ff;
   logic [TGT_W-1:0]     target_ff;
   logic [SPAN_W-1:0]    pos_ff;
   logic [SPAN_W-1:0]    cur_g_ff;
   logic [GW-1:0]        tgt_pos_ff;
   logic [GW-1:0]        prev_pos_ff;
   logic [SPAN_W-1:0]    prev_g_ff;
   logic                 prev_alloc_ff;
   logic                 has_prev_ff;
   logic [1:0]           status_ff;
   logic [OFFSET_W-1:0]  offset_ff;

   logic [CW-1:0]        pos_sum;
   logic [SPAN_W-1:0]    next_pos;
   logic                 rd_en;
   logic [GW-1:0]        rd_addr;
   logic                 wr_en;
   logic [GW-1:0]        wr_addr;
   entry_type            wr_data;
   entry_type            reset_entry;

   always_comb begin
      reset_entry       = '0;
      reset_entry.alloc = 1'b0;
      reset_entry.span  = (addr_q_ff == '0) ? SPAN_W'(NGRAN) : '0;
      rd_entry          = valid_q_ff ? mem_q_ff : reset_entry;
   end

   assign pos_sum  = CW'(pos_ff) + CW'(rd_entry.span);
   assign next_pos = SPAN_W'(pos_sum);

   assign sts.is_free     = is_free_ff;
   assign sts.size_zero   = size_zero_ff;
   assign sts.bad_ptr     = bad_ptr_ff;
   assign sts.g_ok        = (rd_entry.span != '0) && (pos_sum <= CW'(NGRAN));
   assign sts.fit         = !rd_entry.alloc && (CW'(rd_entry.span) >= CW'(need_ff));
   assign sts.split       = CW'(rd_entry.span) >= (CW'(need_ff) + CW'(MIN_SPLIT_GRAN));
   assign sts.at_target   = CW'(pos_ff) == CW'(target_ff);
   assign sts.past_target = CW'(pos_ff) > CW'(target_ff);
   assign sts.next_end    = pos_sum >= CW'(NGRAN);
   assign sts.alloc_bit   = rd_entry.alloc;
   assign sts.prev_merge  = has_prev_ff && !prev_alloc_ff;

   assign rd_en   = cmd.rd_pos || cmd.rd_next;
   assign rd_addr = cmd.rd_next ? GW'(next_pos) : GW'(pos_ff);

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = GW'(pos_ff);
      wr_data = '0;
      case (cmd.wr_op)
         WR_ALLOC: begin
            wr_data.alloc = 1'b1;
            wr_data.span  = sts.split ? SPAN_W'(need_ff) : rd_entry.span;
         end
         WR_SPLIT: begin
            wr_addr      = GW'(CW'(pos_ff) + CW'(need_ff));
            wr_data.span = SPAN_W'(CW'(cur_g_ff) - CW'(need_ff));
         end
         WR_TGT: begin
            wr_addr      = tgt_pos_ff;
            wr_data.span = cur_g_ff;
         end
         WR_PREV: begin
            wr_addr      = prev_pos_ff;
            wr_data.span = SPAN_W'(CW'(prev_g_ff) + CW'(cur_g_ff));
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         valid_q_ff  <= 1'b0;
         addr_q_ff   <= '0;
         has_prev_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            valid_q_ff <= valid_ff[rd_addr];
            addr_q_ff  <= rd_addr;
         end
         if (cmd.load) begin
            has_prev_ff <= 1'b0;
         end else if (cmd.keep_prev) begin
            has_prev_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_free_ff   <= (req_word.req_type == REQ_FREE);
         size_zero_ff <= (req_word.alloc_size == '0);
         bad_ptr_ff   <= (req_word.free_offset[GS-1:0] != GS'(HEADER_BYTES));
         need_ff      <= NEED_W'(((SIZE_W+1)'(req_word.alloc_size)
                         + (SIZE_W+1)'(HEADER_BYTES + GRANULE_BYTES - 1)) >> GS);
         target_ff    <= req_word.free_offset[OFFSET_W-1:GS];
         pos_ff       <= '0;
      end else if (cmd.rd_next) begin
         pos_ff <= next_pos;
      end
      if (cmd.keep_prev) begin
         prev_pos_ff   <= GW'(pos_ff);
         prev_g_ff     <= rd_entry.span;
         prev_alloc_ff <= rd_entry.alloc;
      end
      if (cmd.keep_g) begin
         cur_g_ff   <= rd_entry.span;
         tgt_pos_ff <= GW'(pos_ff);
      end else if (cmd.merge) begin
         cur_g_ff <= (sts.g_ok && !rd_entry.alloc)
                   ? SPAN_W'(CW'(cur_g_ff) + CW'(rd_entry.span)) : cur_g_ff;
      end
      if (cmd.finish) begin
         status_ff <= cmd.fin_status;
         offset_ff <= (cmd.fin_status == STATUS_OK && !is_free_ff)
                    ? OFFSET_W'({pos_ff, GS'(HEADER_BYTES)}) : '0;
      end
   end

   assign rsp_word.status         = status_ff;
   assign rsp_word.payload_offset = offset_ff;

endmodule

`default_nettype wire
